FILE: sv/ftwm_pkg.sv
// ----------------------------------------------------------------------------
// Frame time window monitor package
// Register indexes, rate constants and reset values shared by the monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package ftwm_pkg;

    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_MONITOR_EN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALERTS_EN  = 2'd3;

    localparam int RATE_W = 20;
    localparam logic [RATE_W-1:0] RATE_FULL = 20'd1000000;

    localparam logic [31:0] PERIOD_RESET = 32'd1000000;
    localparam logic [31:0] THRESH_RESET = 32'd33000;

    typedef struct packed {
        logic updated;
        logic warning;
        logic recovered;
    } t_event_flags;

endpackage

`default_nettype wire

FILE: sv/frame_time_window_monitor_unit.sv
// ----------------------------------------------------------------------------
// Frame time window monitor
// Keeps a ring of recent frame durations and, once per update period,
// recomputes window average, window peak and frame rate.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  input     in         i_valid / o_ready         i_frame_duration_us
//  result    out        o_valid / i_ready         o_current_frame_us .. flags
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_addr, i_cfg_data
//
//  A disabled word goes from accept straight to the output step; an enabled
//  word without recompute passes ring read, push and output. A recompute
//  adds a peak scan over the filled entries and a divider pass for the
//  average, plus one more divider pass for the rate unless the duration is zero.
//  Reset is synchronous and clears control state; the ring is not cleared.
//  A stalled result lets one more word run up to the output step and wait.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_time_window_monitor_unit #(
    parameter int WINDOW_DEPTH = 60,
    parameter int TIME_BITS    = 24
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [TIME_BITS-1:0]            i_frame_duration_us,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [TIME_BITS-1:0]                 o_current_frame_us,
    output logic [TIME_BITS-1:0]                 o_average_frame_us,
    output logic [TIME_BITS-1:0]                 o_peak_frame_us,
    output logic [ftwm_pkg::RATE_W-1:0]          o_frame_rate,
    output logic                                 o_metrics_updated,
    output logic                                 o_warning_event,
    output logic                                 o_recovered_event,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ftwm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [TIME_BITS-1:0]            i_cfg_data
);

    localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int TOT_W  = TIME_BITS + FILL_W;
    localparam int DIV_N  = (TOT_W > ftwm_pkg::RATE_W) ? TOT_W : ftwm_pkg::RATE_W;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_READ      = 4'd1;
    localparam logic [3:0] ST_PUSH      = 4'd2;
    localparam logic [3:0] ST_SCAN      = 4'd3;
    localparam logic [3:0] ST_SCAN_END  = 4'd4;
    localparam logic [3:0] ST_AVG_GO    = 4'd5;
    localparam logic [3:0] ST_AVG_WAIT  = 4'd6;
    localparam logic [3:0] ST_RATE_GO   = 4'd7;
    localparam logic [3:0] ST_RATE_WAIT = 4'd8;
    localparam logic [3:0] ST_OUT       = 4'd9;

    logic [TIME_BITS-1:0] r_mem [WINDOW_DEPTH];
    logic [TIME_BITS-1:0] r_rd;
    logic [IDX_W-1:0]     w_rd_addr;

    logic [3:0]           r_state;
    logic [3:0]           n_state;
    logic [TIME_BITS-1:0] r_d;
    logic [FILL_W-1:0]    r_fill;
    logic [IDX_W-1:0]     r_head;
    logic [IDX_W-1:0]     r_idx;
    logic [TOT_W-1:0]     r_total;
    logic [TIME_BITS:0]   r_acc;
    logic [TIME_BITS-1:0] r_last;
    logic [TIME_BITS-1:0] r_avg;
    logic [TIME_BITS-1:0] r_peak;
    logic [TIME_BITS-1:0] r_peak_acc;
    logic                 r_cmp_vld;
    logic [ftwm_pkg::RATE_W-1:0] r_rate;
    logic                 r_was_good;
    ftwm_pkg::t_event_flags r_flags;
    logic                 r_out_vld;

    logic                 r_mon_en;
    logic [TIME_BITS-1:0] r_period;
    logic [TIME_BITS-1:0] r_thresh;
    logic                 r_alert_en;

    logic                 w_accept;
    logic                 w_full;
    logic [TIME_BITS:0]   w_acc_sum;
    logic                 w_update;
    logic                 w_good;
    logic [TIME_BITS-1:0] w_peak_next;
    logic                 w_out_free;

    logic                 w_div_start;
    logic [DIV_N-1:0]     w_div_dividend;
    logic [TIME_BITS-1:0] w_div_divisor;
    logic                 w_div_done;
    logic [DIV_N-1:0]     w_div_quo;

    assign w_accept    = i_valid && o_ready;
    assign w_full      = r_fill == FILL_W'(WINDOW_DEPTH);
    assign w_acc_sum   = r_acc + {1'b0, r_d};
    assign w_update    = w_acc_sum >= {1'b0, r_period};
    assign w_good      = r_d < r_thresh;
    assign w_peak_next = (r_cmp_vld && (r_rd > r_peak_acc)) ? r_rd : r_peak_acc;
    assign w_out_free  = !r_out_vld || i_ready;
    assign w_rd_addr   = (r_state == ST_SCAN) ? r_idx : r_head;

    assign w_div_start    = (r_state == ST_AVG_GO) || (r_state == ST_RATE_GO);
    assign w_div_dividend = (r_state == ST_RATE_GO) ? DIV_N'(ftwm_pkg::RATE_FULL)
                                                    : DIV_N'(r_total);
    assign w_div_divisor  = (r_state == ST_RATE_GO) ? r_d : TIME_BITS'(r_fill);

    ftwm_divider #(
        .N(DIV_N),
        .M(TIME_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PUSH) begin
            r_mem[r_head] <= r_d;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mon_en   <= 1'b1;
            r_period   <= TIME_BITS'(ftwm_pkg::PERIOD_RESET);
            r_thresh   <= TIME_BITS'(ftwm_pkg::THRESH_RESET);
            r_alert_en <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                ftwm_pkg::CFG_MONITOR_EN: r_mon_en   <= i_cfg_data[0];
                ftwm_pkg::CFG_PERIOD:     r_period   <= i_cfg_data;
                ftwm_pkg::CFG_THRESHOLD:  r_thresh   <= i_cfg_data;
                ftwm_pkg::CFG_ALERTS_EN:  r_alert_en <= i_cfg_data[0];
                default:                  r_mon_en   <= r_mon_en;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (w_accept) n_state = r_mon_en ? ST_READ : ST_OUT;
            ST_READ:      n_state = ST_PUSH;
            ST_PUSH:      n_state = w_update ? ST_SCAN : ST_OUT;
            ST_SCAN:      if (FILL_W'(r_idx) == r_fill - 1'b1) n_state = ST_SCAN_END;
            ST_SCAN_END:  n_state = ST_AVG_GO;
            ST_AVG_GO:    n_state = ST_AVG_WAIT;
            ST_AVG_WAIT:  if (w_div_done) n_state = (r_d != '0) ? ST_RATE_GO : ST_OUT;
            ST_RATE_GO:   n_state = ST_RATE_WAIT;
            ST_RATE_WAIT: if (w_div_done) n_state = ST_OUT;
            ST_OUT:       if (w_out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fill     <= '0;
            r_head     <= '0;
            r_total    <= '0;
            r_acc      <= '0;
            r_last     <= '0;
            r_avg      <= '0;
            r_peak     <= '0;
            r_rate     <= '0;
            r_was_good <= 1'b1;
            r_flags    <= '0;
            r_cmp_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= r_state == ST_SCAN;
            if ((r_state == ST_OUT) && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_d     <= i_frame_duration_us;
                        r_flags <= '0;
                    end
                end
                ST_PUSH: begin
                    r_last     <= r_d;
                    r_total    <= r_total - (w_full ? TOT_W'(r_rd) : '0) + TOT_W'(r_d);
                    r_fill     <= w_full ? r_fill : r_fill + 1'b1;
                    r_head     <= (r_head == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    r_acc      <= w_update ? '0 : w_acc_sum;
                    r_idx      <= '0;
                    r_peak_acc <= '0;
                    r_flags.updated <= w_update;
                    if (r_alert_en) begin
                        r_flags.warning   <= r_was_good && !w_good;
                        r_flags.recovered <= !r_was_good && w_good;
                        r_was_good        <= w_good;
                    end
                end
                ST_SCAN: begin
                    r_idx      <= r_idx + 1'b1;
                    r_peak_acc <= w_peak_next;
                end
                ST_SCAN_END: begin
                    r_peak <= w_peak_next;
                end
                ST_AVG_WAIT: begin
                    if (w_div_done) begin
                        r_avg <= w_div_quo[TIME_BITS-1:0];
                        if (r_d == '0) begin
                            r_rate <= ftwm_pkg::RATE_FULL;
                        end
                    end
                end
                ST_RATE_WAIT: begin
                    if (w_div_done) begin
                        r_rate <= w_div_quo[ftwm_pkg::RATE_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_out_free) begin
            o_current_frame_us <= r_last;
            o_average_frame_us <= r_avg;
            o_peak_frame_us    <= r_peak;
            o_frame_rate       <= r_rate;
            o_metrics_updated  <= r_flags.updated;
            o_warning_event    <= r_flags.warning;
            o_recovered_event  <= r_flags.recovered;
        end
    end

    assign o_ready = r_state == ST_IDLE;
    assign o_valid = r_out_vld;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW_DEPTH))
        else $error("window fill exceeds depth");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_flags.warning && r_flags.recovered))
        else $error("warning and recovery raised together");

    a_disabled_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_mon_en) |=> (r_state == ST_OUT))
        else $error("disabled word did not go straight to output");

    a_avg_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_AVG_WAIT) && w_div_done) |=>
            ((r_state == ST_RATE_GO) || (r_state == ST_OUT)))
        else $error("sequencer left average step wrongly");

    a_update_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_PUSH) && w_update) |=> (r_state == ST_SCAN) && (r_fill != '0))
        else $error("recompute started on an empty window");

endmodule

`default_nettype wire

FILE: sv/ftwm_divider.sv
// ----------------------------------------------------------------------------
// Frame time window monitor divider
// Restoring divider, one quotient bit per cycle, shared by average and rate.
// ----------------------------------------------------------------------------
`default_nettype none

module ftwm_divider #(
    parameter int N = 32,
    parameter int M = 24
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [N-1:0] i_dividend,
    input  wire logic [M-1:0] i_divisor,
    output logic              o_done,
    output logic [N-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(N + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [M-1:0]     r_div;
    logic [M-1:0]     r_rem;
    logic [N-1:0]     r_quo;

    logic [M:0] w_shifted;
    logic       w_ge;
    logic [M:0] w_diff;

    assign w_shifted = {r_rem, r_quo[N-1]};
    assign w_ge      = w_shifted >= {1'b0, r_div};
    assign w_diff    = w_shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[M-1:0] : w_shifted[M-1:0];
            r_quo <= {r_quo[N-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire
